### sv/ncm_pkg.sv
// ----------------------------------------------------------------------------
// ncm_pkg
// Shared types, constants and the sine table generator for the NCO mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ncm_pkg;

	// Width of the phase step register as seen on the configuration port.
	localparam int CFG_W = 32;

	// Table magnitude width and signed trig operand width (Q1.15).
	localparam int SINE_W = 15;
	localparam int TRIG_W = 16;
	localparam int FRAC_BITS = 15;

	// Queue between the front and the back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// Sine generator constants, Q30 fixed point.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned SINE_AMP = 64'd32767;
	localparam int TAYLOR_TERMS = 9;
	localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
		'{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342};

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	// Quarter-wave entry k for a table of 2^abits entries, sampled at the
	// center of each step. Evaluated at elaboration only.
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
		input int unsigned abits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] mag;
		longint acc;
		x = (HALF_PI_Q30 * (64'(k) * 64'd2 + 64'd1)) >> (abits + 1);
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int n = 0; n < TAYLOR_TERMS; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if ((n & 1) == 0) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		mag = (64'(acc) * SINE_AMP + (64'd1 << 29)) >> 30;
		return mag[SINE_W-1:0];
	endfunction

endpackage

### sv/nco_complex_mixer.sv
// ----------------------------------------------------------------------------
// nco_complex_mixer
// Digital down-converter mixer: real sample times exp(-j*phase) from an NCO.
//
// Input words (sample, block_end) arrive on in_valid/in_ready; each gives one
// complex word (out_i, out_q, out_block_end) on out_valid/out_ready. out_i is
// sample*cos and out_q is -sample*sin, Q1.15, rounded and saturated.
// The user must write phase_step via cfg_we/cfg_wdata only while the block is
// idle; the block does not enforce this. The phase starts at zero and
// advances by phase_step after every accepted word, which then passes the
// queue and s1, s2, s3. Throughput is one word per cycle with out_ready high,
// set by the single phase adder and the table/multiply/round back pipeline.
// Reset clears the phase, the step, the queue and all valid flags.
// When the receiver stalls, the output register holds its word and the back
// pipeline freezes; the four-word queue keeps taking input until it fills,
// and in_ready then drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nco_complex_mixer import ncm_pkg::*; #(
	parameter int PHASE_BITS = 32,
	parameter int TABLE_ADDR_BITS = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_W-1:0]              cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          block_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] out_i,
	output logic signed [SAMPLE_BITS-1:0] out_q,
	output logic                          out_block_end
);

	localparam int QDATA_W = SAMPLE_BITS + TABLE_ADDR_BITS + 3;

	logic               push;
	logic               pop;
	logic [QDATA_W-1:0] push_data;
	logic [QDATA_W-1:0] pop_data;
	fifo_status_t       fifo_status;

	ncm_front #(
		.PHASE_BITS     (PHASE_BITS),
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.block_end  (block_end),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fifo_status(fifo_status),
		.push       (push),
		.push_data  (push_data)
	);

	ncm_fifo #(
		.DATA_W(QDATA_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.pop_data   (pop_data),
		.fifo_status(fifo_status)
	);

	ncm_back #(
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_status  (fifo_status),
		.pop_data     (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_i        (out_i),
		.out_q        (out_q),
		.out_block_end(out_block_end)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_status.full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_status.empty)
		else $error("queue read while empty");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> !fifo_status.empty)
		else $error("queue empty after a write without a read");
`endif

endmodule

### sv/ncm_front.sv
// ----------------------------------------------------------------------------
// ncm_front
// Accepts input words, runs the phase accumulator and queues each sample
// together with the table address of its phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncm_front import ncm_pkg::*; #(
	parameter int PHASE_BITS = 32,
	parameter int TABLE_ADDR_BITS = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  logic signed [SAMPLE_BITS-1:0]                sample,
	input  logic                                         block_end,
	input  logic                                         cfg_we,
	input  logic [CFG_W-1:0]                             cfg_wdata,
	input  fifo_status_t                                 fifo_status,
	output logic                                         push,
	output logic [SAMPLE_BITS+TABLE_ADDR_BITS+2:0]       push_data
);

	localparam int ADDR_W = TABLE_ADDR_BITS + 2;

	logic [PHASE_BITS-1:0] phase_step_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [ADDR_W-1:0]     addr;

	assign in_ready = !fifo_status.full;
	assign push = in_valid && in_ready;
	assign addr = phase_q[PHASE_BITS-1 -: ADDR_W];
	assign push_data = {sample, block_end, addr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
		end else if (cfg_we) begin
			phase_step_q <= PHASE_BITS'(cfg_wdata);
		end
	end

	// The current word uses the phase as it stands; the step is added after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (push) begin
			phase_q <= phase_q + phase_step_q;
		end
	end

endmodule

### sv/ncm_fifo.sv
// ----------------------------------------------------------------------------
// ncm_fifo
// Short queue between the front and the back of the mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncm_fifo import ncm_pkg::*; #(
	parameter int DATA_W = 29
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output fifo_status_t      fifo_status
);

	logic [DATA_W-1:0]     mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;

	assign fifo_status.full = (count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
	assign fifo_status.empty = (count_q == '0);
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/ncm_sine_rom.sv
// ----------------------------------------------------------------------------
// ncm_sine_rom
// Quarter-wave sine table with two registered read ports, giving cosine and
// negated sine of one full-wave phase address as magnitude and sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncm_sine_rom import ncm_pkg::*; #(
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [TABLE_ADDR_BITS+1:0]   addr,
	output logic [SINE_W-1:0]            cos_mag,
	output logic                         cos_neg,
	output logic [SINE_W-1:0]            nsin_mag,
	output logic                         nsin_neg
);

	localparam int TBL_N = 1 << TABLE_ADDR_BITS;

	logic [SINE_W-1:0]          rom_tbl [TBL_N];
	logic [1:0]                 quad_s;
	logic [1:0]                 quad_c;
	logic [TABLE_ADDR_BITS-1:0] idx;
	logic [TABLE_ADDR_BITS-1:0] idx_s;
	logic [TABLE_ADDR_BITS-1:0] idx_c;

	for (genvar k = 0; k < TBL_N; k++) begin : g_rom
		assign rom_tbl[k] = sine_entry(k, TABLE_ADDR_BITS);
	end

	// Cosine is the sine a quarter turn later. Odd quadrants read the table
	// backwards, and the upper half of the circle flips the sign.
	assign quad_s = addr[TABLE_ADDR_BITS+1:TABLE_ADDR_BITS];
	assign quad_c = quad_s + 2'd1;
	assign idx = addr[TABLE_ADDR_BITS-1:0];
	assign idx_s = quad_s[0] ? ~idx : idx;
	assign idx_c = quad_c[0] ? ~idx : idx;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_mag <= rom_tbl[idx_c];
			cos_neg <= quad_c[1];
			nsin_mag <= rom_tbl[idx_s];
			nsin_neg <= !quad_s[1];
		end
	end

endmodule

### sv/ncm_back.sv
// ----------------------------------------------------------------------------
// ncm_back
// Takes queued words, reads the table, multiplies, rounds and saturates,
// and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ncm_back import ncm_pkg::*; #(
	parameter int TABLE_ADDR_BITS = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  fifo_status_t                             fifo_status,
	input  logic [SAMPLE_BITS+TABLE_ADDR_BITS+2:0]   pop_data,
	output logic                                     pop,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [SAMPLE_BITS-1:0]            out_i,
	output logic signed [SAMPLE_BITS-1:0]            out_q,
	output logic                                     out_block_end
);

	localparam int ADDR_W = TABLE_ADDR_BITS + 2;
	localparam int PROD_W = SAMPLE_BITS + TRIG_W;
	localparam int RND_W = PROD_W + 1 - FRAC_BITS;
	localparam logic signed [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [RND_W-1:0] SAT_HI = {3'b000, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic signed [RND_W-1:0] SAT_LO = {3'b111, {(SAMPLE_BITS - 1){1'b0}}};

	logic                          adv;
	logic signed [SAMPLE_BITS-1:0] pop_sample;
	logic                          pop_block_end;
	logic [ADDR_W-1:0]             pop_addr;

	logic [SINE_W-1:0]             cos_mag;
	logic                          cos_neg;
	logic [SINE_W-1:0]             nsin_mag;
	logic                          nsin_neg;
	logic signed [TRIG_W-1:0]      cos_val;
	logic signed [TRIG_W-1:0]      nsin_val;
	logic signed [PROD_W-1:0]      mul_i;
	logic signed [PROD_W-1:0]      mul_q;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          block_end_s1;
	logic                          valid_s2;
	logic signed [PROD_W-1:0]      prod_i_s2;
	logic signed [PROD_W-1:0]      prod_q_s2;
	logic                          block_end_s2;
	logic                          valid_s3;
	logic signed [SAMPLE_BITS-1:0] out_i_s3;
	logic signed [SAMPLE_BITS-1:0] out_q_s3;
	logic                          block_end_s3;

	// Round half up at bit 15, then clamp to the signed sample range.
	function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0]    v;
		logic signed [RND_W-1:0]   r;
		logic signed [SAMPLE_BITS-1:0] res;
		v = {p[PROD_W-1], p} + RND_HALF;
		r = v[PROD_W:FRAC_BITS];
		if (r > SAT_HI) begin
			res = SAT_HI[SAMPLE_BITS-1:0];
		end else if (r < SAT_LO) begin
			res = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			res = r[SAMPLE_BITS-1:0];
		end
		return res;
	endfunction

	// The whole back pipeline moves unless a result sits unclaimed at the end.
	assign adv = !valid_s3 || out_ready;
	assign pop = adv && !fifo_status.empty;
	assign {pop_sample, pop_block_end, pop_addr} = pop_data;

	ncm_sine_rom #(
		.TABLE_ADDR_BITS(TABLE_ADDR_BITS)
	) u_rom (
		.clk     (clk),
		.en      (adv),
		.addr    (pop_addr),
		.cos_mag (cos_mag),
		.cos_neg (cos_neg),
		.nsin_mag(nsin_mag),
		.nsin_neg(nsin_neg)
	);

	assign cos_val = cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
	assign nsin_val = nsin_neg ? -$signed({1'b0, nsin_mag}) : $signed({1'b0, nsin_mag});
	assign mul_i = sample_s1 * cos_val;
	assign mul_q = sample_s1 * nsin_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= pop_sample;
			block_end_s1 <= pop_block_end;
			prod_i_s2 <= mul_i;
			prod_q_s2 <= mul_q;
			block_end_s2 <= block_end_s1;
			out_i_s3 <= round_sat(prod_i_s2);
			out_q_s3 <= round_sat(prod_q_s2);
			block_end_s3 <= block_end_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_i = out_i_s3;
	assign out_q = out_q_s3;
	assign out_block_end = block_end_s3;

endmodule
